// ----- hw/rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the score rank table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int SCORE_W      = 64;
  localparam int LEN_W        = 7;
  localparam int RANK_W       = 8;
  localparam int TC_W         = 32;
  localparam int IN_DATA_W    = 168;
  localparam int OUT_DATA_W   = 144;

  localparam logic [LEN_W-1:0]  DEF_TOP_COUNT = 7'd10;
  localparam logic [RANK_W-1:0] RANK_ABSENT   = 8'hFF;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_TOP    = 2'd1;
  localparam logic [1:0] FUNC_RANK   = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_RANK   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   ref_key;
    logic [SCORE_W-1:0] ref_score;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REMOVE,
    ST_INSERT,
    ST_GT,
    ST_COUNT,
    ST_RESP,
    ST_TOP
  } state_t;

endpackage

// ----- hw/rtl/srt_cell.sv -----
// ----------------------------------------------------------------------------
// srt_cell
// One slot of the sorted entry chain: compare, shift, insert, rotate.
// ----------------------------------------------------------------------------
module srt_cell import srt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    prev_ent,
  input  logic      prev_before,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      precedes,
  output logic      match,
  output logic      gt
);

  logic               valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic               score_eq, ref_gt, own_gt, stays;

  always_comb begin
    score_eq = (score_r == cmd.ref_score);
    ref_gt   = $signed(cmd.ref_score) > $signed(score_r);
    own_gt   = $signed(score_r) > $signed(cmd.ref_score);
    precedes = !valid_r || ref_gt || (score_eq && (cmd.ref_key < key_r));
    stays    = valid_r && (own_gt || (score_eq && (key_r < cmd.ref_key)));
    match    = valid_r && (key_r == cmd.ref_key);
    gt       = valid_r && own_gt;
    ent      = '{valid: valid_r, key: key_r, score: score_r};
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    score_nxt = score_r;
    case (cmd.op)
      CELL_ROTATE: begin
        valid_nxt = next_ent.valid;
        key_nxt   = next_ent.key;
        score_nxt = next_ent.score;
      end
      CELL_REMOVE: begin
        if (!stays) begin
          valid_nxt = next_ent.valid;
          key_nxt   = next_ent.key;
          score_nxt = next_ent.score;
        end
      end
      CELL_INSERT: begin
        if (prev_before) begin
          valid_nxt = prev_ent.valid;
          key_nxt   = prev_ent.key;
          score_nxt = prev_ent.score;
        end else if (precedes) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.ref_key;
          score_nxt = cmd.ref_score;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    score_r <= score_nxt;
  end

endmodule

// ----- hw/rtl/score_rank_table.sv -----
// ----------------------------------------------------------------------------
// score_rank_table
// Leaderboard table kept sorted in a chain of cells; update, top list, rank.
// ----------------------------------------------------------------------------
// Update: find, remove if present, insert or drop, respond.
// Rank: find, then for a present id compare and count the higher entries; respond.
// Top list: one entry per cycle while the output is not stalled; the chain rotates through
//   all CAPACITY cells, holding on stalls while entries remain; an empty list gets an empty result.
// One item at a time; in_tready returns the cycle after the item finishes.
// Synchronous active-low reset empties the table, default count back to 10.
module score_rank_table import srt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // player_id, new_score, count_given, top_count, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, entry_id, entry_score, list_length, rank
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data
);

  localparam int FW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]   id_r, id_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [KEY_W-1:0]   mkey_r, mkey_nxt;
  logic [SCORE_W-1:0] mscore_r, mscore_nxt;
  logic               upd_r, upd_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      len_r, len_nxt;
  logic [FW-1:0]      cnt_r, cnt_nxt;
  logic [CAPACITY-1:0] gt_r, gt_nxt;
  logic [1:0]         rkind_r, rkind_nxt;
  logic               rstat_r, rstat_nxt;
  logic [RANK_W-1:0]  rrank_r, rrank_nxt;
  logic [LEN_W-1:0]   deflen_r;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_room;

  cell_cmd_t           cmd;
  entry_t              ent   [CAPACITY];
  entry_t              prev_e[CAPACITY];
  entry_t              next_e[CAPACITY];
  logic [CAPACITY-1:0] before_v, match_v, gt_v;
  logic [CAPACITY-1:0] prev_b;

  logic               in_acc, found;
  logic [KEY_W-1:0]   fkey;
  logic [SCORE_W-1:0] fscore;
  logic [FW-1:0]      hi_cnt;
  logic [TC_W-1:0]    tc;
  logic               cnt_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_room  = !out_valid_r || out_tready;
  assign tc        = in_tdata[160:129];
  assign cnt_done  = (cnt_r == FW'(CAPACITY - 1));

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign prev_e[g] = '0;
        assign prev_b[g] = 1'b0;
      end else begin : g_body
        assign prev_e[g] = ent[g-1];
        assign prev_b[g] = before_v[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        always_comb begin
          next_e[g]       = ent[0];
          next_e[g].valid = ent[0].valid && (cmd.op == CELL_ROTATE);
        end
      end else begin : g_mid
        assign next_e[g] = ent[g+1];
      end
      srt_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .prev_ent    (prev_e[g]),
        .prev_before (prev_b[g]),
        .next_ent    (next_e[g]),
        .ent         (ent[g]),
        .precedes    (before_v[g]),
        .match       (match_v[g]),
        .gt          (gt_v[g])
      );
    end
  endgenerate

  always_comb begin
    found  = |match_v;
    fkey   = '0;
    fscore = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      fkey   = fkey | (match_v[i] ? ent[i].key : '0);
      fscore = fscore | (match_v[i] ? ent[i].score : '0);
    end
  end

  // higher entries form a prefix of the sorted chain
  always_comb begin
    hi_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (gt_r[i]) begin
        hi_cnt = FW'(i + 1);
      end
    end
  end

  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.ref_key   = id_r;
    cmd.ref_score = score_r;
    case (state_r)
      ST_REMOVE: begin
        cmd.op        = CELL_REMOVE;
        cmd.ref_key   = mkey_r;
        cmd.ref_score = mscore_r;
      end
      ST_INSERT: begin
        cmd.op = CELL_INSERT;
      end
      ST_GT: begin
        cmd.ref_key   = mkey_r;
        cmd.ref_score = mscore_r;
      end
      ST_TOP: begin
        if (cnt_r >= len_r || out_room) begin
          cmd.op = CELL_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            FUNC_UPDATE: state_nxt = ST_FIND;
            FUNC_RANK:   state_nxt = ST_FIND;
            FUNC_TOP:    state_nxt = (len_nxt == '0) ? ST_RESP : ST_TOP;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        if (upd_r) begin
          if (found) begin
            state_nxt = ST_REMOVE;
          end else if (fill_r == FW'(CAPACITY)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_INSERT;
          end
        end else begin
          state_nxt = found ? ST_GT : ST_RESP;
        end
      end
      ST_REMOVE: state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_RESP;
      ST_GT:     state_nxt = ST_COUNT;
      ST_COUNT:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_room) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TOP: begin
        if (cmd.op == CELL_ROTATE && cnt_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    id_nxt     = id_r;
    score_nxt  = score_r;
    upd_nxt    = upd_r;
    mkey_nxt   = mkey_r;
    mscore_nxt = mscore_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    gt_nxt     = gt_r;
    rkind_nxt  = rkind_r;
    rstat_nxt  = rstat_r;
    rrank_nxt  = rrank_r;
    if (in_tuser == FUNC_TOP) begin
      if (in_tdata[128]) begin
        if (tc[TC_W-1] || tc >= TC_W'(fill_r)) begin
          len_nxt = fill_r;
        end else begin
          len_nxt = FW'(tc);
        end
      end else if (LEN_W'(fill_r) <= deflen_r) begin
        len_nxt = fill_r;
      end else begin
        len_nxt = FW'(deflen_r);
      end
      if (!in_acc) begin
        len_nxt = len_r;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          id_nxt    = in_tdata[63:0];
          score_nxt = in_tdata[127:64];
          upd_nxt   = (in_tuser == FUNC_UPDATE);
          cnt_nxt   = '0;
          rkind_nxt = KIND_EMPTY;
          rstat_nxt = 1'b0;
          rrank_nxt = '0;
        end
      end
      ST_FIND: begin
        mkey_nxt   = fkey;
        mscore_nxt = fscore;
        if (upd_r) begin
          rkind_nxt = KIND_STATUS;
          rstat_nxt = !found && (fill_r == FW'(CAPACITY));
        end else begin
          rkind_nxt = KIND_RANK;
          rrank_nxt = RANK_ABSENT;
        end
      end
      ST_REMOVE: fill_nxt = fill_r - FW'(1);
      ST_INSERT: fill_nxt = fill_r + FW'(1);
      ST_GT:     gt_nxt   = gt_v;
      ST_COUNT:  rrank_nxt = RANK_W'(hi_cnt) + RANK_W'(1);
      ST_TOP: begin
        if (cmd.op == CELL_ROTATE) begin
          cnt_nxt = cnt_r + FW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_RESP: begin
        if (out_room) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt[0]        = rstat_r;
          out_data_nxt[143:136]  = rrank_r;
          out_kind_nxt           = rkind_r;
          out_last_nxt           = 1'b1;
        end
      end
      ST_TOP: begin
        if (cnt_r < len_r && out_room) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt[64:1]     = ent[0].key;
          out_data_nxt[128:65]   = ent[0].score;
          out_data_nxt[135:129]  = LEN_W'(len_r);
          out_kind_nxt           = KIND_ENTRY;
          out_last_nxt           = (cnt_r + FW'(1) == len_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      deflen_r    <= DEF_TOP_COUNT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        deflen_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    score_r    <= score_nxt;
    upd_r      <= upd_nxt;
    mkey_r     <= mkey_nxt;
    mscore_r   <= mscore_nxt;
    len_r      <= len_nxt;
    cnt_r      <= cnt_nxt;
    gt_r       <= gt_nxt;
    rkind_r    <= rkind_nxt;
    rstat_r    <= rstat_nxt;
    rrank_r    <= rrank_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (ent[0].valid == (fill_r != '0)))
    else $error("chain head disagrees with fill count");

  a_entry_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ENTRY) |-> (out_data_r[135:129] != '0))
    else $error("top entry with zero list length");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("insert did not grow the table");

endmodule

// ----- sim/score_rank_table_tb.sv -----
// ----------------------------------------------------------------------------
// score_rank_table_tb
// Self-checking bench for the score rank table: updates, top lists and rank
// queries against an in-bench model of the table, with random stalls on both
// streams, a long output hold-off and default count changes between phases.
// ----------------------------------------------------------------------------
module score_rank_table_tb;
  import srt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam int         CAP          = CAPACITY_DEF;
  localparam int         N_RANDOM     = 150;

  typedef struct {
    logic [1:0]         kind;
    logic               status;
    logic [KEY_W-1:0]   id;
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   len;
    logic [RANK_W-1:0]  rank;
    logic               last;
  } board_res_t;

  typedef struct {
    logic [1:0]           func;
    logic [KEY_W-1:0]     id;
    logic [SCORE_W-1:0]   score;
    logic                 given;
    logic [TC_W-1:0]      tc;
    bit                   typed;
    logic [1:0]           t_kind;
    logic                 t_status;
    logic [RANK_W-1:0]    t_rank;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;

  score_rank_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // table model
  bit                 tbl_valid [CAP];
  logic [KEY_W-1:0]   tbl_key   [CAP];
  logic [SCORE_W-1:0] tbl_score [CAP];
  logic [LEN_W-1:0]   tbl_default = DEF_TOP_COUNT;

  board_res_t         pending_q[$];
  logic [KEY_W-1:0]   id_pool[$];
  stim_row_t          dir_tbl[$];
  int errors = 0, n_items = 0, n_results = 0, n_dropped = 0, n_tops = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0, hold_cnt = 0;
  bit hold_req = 0;

  function automatic void expect_res(board_res_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void add_row(stim_row_t s);
    dir_tbl.insert(dir_tbl.size(), s);
  endfunction

  function automatic board_res_t blank_res(logic [1:0] kind);
    board_res_t r;
    r.kind = kind; r.status = 0; r.id = '0; r.score = '0;
    r.len = '0; r.rank = '0; r.last = 1'b1;
    return r;
  endfunction

  function automatic bit ranks_higher(int a, int b);
    if (tbl_score[a] != tbl_score[b]) return $signed(tbl_score[a]) > $signed(tbl_score[b]);
    return tbl_key[a] < tbl_key[b];
  endfunction

  function automatic int find_player(logic [KEY_W-1:0] id);
    for (int i = 0; i < CAP; i++)
      if (tbl_valid[i] && tbl_key[i] == id) return i;
    return -1;
  endfunction

  function automatic void predict_board(logic [1:0] func, logic [KEY_W-1:0] id,
                                        logic [SCORE_W-1:0] score, logic given,
                                        logic [TC_W-1:0] tc);
    board_res_t r;
    int slot, fill, len, higher, tmp;
    int order[$];
    bit all;
    longint unsigned want;
    case (func)
      FUNC_UPDATE: begin
        r = blank_res(KIND_STATUS);
        slot = find_player(id);
        if (slot < 0)
          for (int i = 0; i < CAP; i++)
            if (!tbl_valid[i]) begin
              slot = i;
              break;
            end
        if (slot < 0) begin
          r.status = 1'b1;
          n_dropped++;
        end else begin
          tbl_valid[slot] = 1; tbl_key[slot] = id; tbl_score[slot] = score;
        end
        expect_res(r);
      end
      FUNC_TOP: begin
        n_tops++;
        for (int i = 0; i < CAP; i++)
          if (tbl_valid[i]) order.insert(order.size(), i);
        fill = order.size();
        for (int i = 1; i < fill; i++)
          for (int j = i; j > 0 && ranks_higher(order[j], order[j-1]); j--) begin
            tmp = order[j]; order[j] = order[j-1]; order[j-1] = tmp;
          end
        all = given && tc[TC_W-1];
        want = given ? longint'(tc) : longint'(tbl_default);
        len = (all || want >= fill) ? fill : int'(want);
        if (len == 0) expect_res(blank_res(KIND_EMPTY));
        for (int i = 0; i < len; i++) begin
          r = blank_res(KIND_ENTRY);
          r.id = tbl_key[order[i]]; r.score = tbl_score[order[i]];
          r.len = LEN_W'(len); r.last = (i == len - 1);
          expect_res(r);
        end
      end
      FUNC_RANK: begin
        r = blank_res(KIND_RANK);
        slot = find_player(id);
        r.rank = RANK_ABSENT;
        if (slot >= 0) begin
          higher = 0;
          for (int i = 0; i < CAP; i++)
            if (tbl_valid[i] && $signed(tbl_score[i]) > $signed(tbl_score[slot])) higher++;
          r.rank = RANK_W'(higher + 1);
        end
        expect_res(r);
      end
      default: ;
    endcase
  endfunction

  // output side: ready with random gaps, long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    board_res_t e;
    logic [OUT_DATA_W-1:0] d;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      d = out_tdata;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d data=%h", out_tuser, d);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_tuser); errors++;
        end
        if (d[0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, d[0]); errors++;
        end
        if (d[64:1] !== e.id) begin
          $error("entry_id: expected %h, got %h", e.id, d[64:1]); errors++;
        end
        if (d[128:65] !== e.score) begin
          $error("entry_score: expected %h, got %h", e.score, d[128:65]); errors++;
        end
        if (d[135:129] !== e.len) begin
          $error("list_length: expected %0d, got %0d", e.len, d[135:129]); errors++;
        end
        if (d[143:136] !== e.rank) begin
          $error("rank: expected %h, got %h", e.rank, d[143:136]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  task automatic send_item(stim_row_t s);
    board_res_t t;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.func;
    in_tdata  <= {7'b0, s.tc, s.given, s.score, s.id};
    do @(posedge clk); while (!in_tready);
    n_items++;
    predict_board(s.func, s.id, s.score, s.given, s.tc);
    if (s.typed) begin
      t = blank_res(s.t_kind);
      t.status = s.t_status;
      t.rank = s.t_rank;
      pending_q[pending_q.size() - 1] = t;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (3 * CAP) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_default(logic [LEN_W-1:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    tbl_default = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic stim_row_t mk(logic [1:0] f, logic [KEY_W-1:0] id,
                                   logic [SCORE_W-1:0] sc, logic g, logic [TC_W-1:0] tc);
    stim_row_t s;
    s.func = f; s.id = id; s.score = sc; s.given = g; s.tc = tc;
    s.typed = 0; s.t_kind = KIND_STATUS; s.t_status = 0; s.t_rank = '0;
    return s;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t s, logic [1:0] k, logic st,
                                         logic [RANK_W-1:0] rk);
    s.typed = 1; s.t_kind = k; s.t_status = st; s.t_rank = rk;
    return s;
  endfunction

  function automatic stim_row_t random_item();
    int p;
    logic [KEY_W-1:0] id;
    logic [SCORE_W-1:0] sc;
    logic [TC_W-1:0] tc;
    p = $urandom_range(99);
    if ($urandom_range(9) < 7 && id_pool.size() > 0)
      id = id_pool[$urandom_range(id_pool.size() - 1)];
    else
      id = {$urandom, $urandom};
    sc = ($urandom_range(1)) ? 64'($signed($urandom_range(10)) - 5) : {$urandom, $urandom};
    case ($urandom_range(3))
      0: tc = $urandom_range(70);
      1: tc = -$urandom_range(1, 5);
      2: tc = $urandom;
      default: tc = $urandom_range(5);
    endcase
    if (p < 40) return mk(FUNC_UPDATE, id, sc, $urandom_range(1), tc);
    if (p < 70) return mk(FUNC_TOP, id, sc, $urandom_range(1), tc);
    if (p < 95) return mk(FUNC_RANK, id, sc, $urandom_range(1), tc);
    return mk(FUNC_IGNORED, id, sc, $urandom_range(1), tc);
  endfunction

  initial begin
    #20ms;
    $display("score_rank_table_tb: FAIL");
    $finish;
  end

  initial begin
    stim_row_t s;
    logic [KEY_W-1:0] k;

    add_row(mk_typed(mk(FUNC_TOP, '0, '0, 0, '0), KIND_EMPTY, 0, '0));
    add_row(mk_typed(mk(FUNC_RANK, '0, '0, 0, '0), KIND_RANK, 0, RANK_ABSENT));
    add_row(mk_typed(mk(FUNC_UPDATE, '0, 64'h8000_0000_0000_0000, 0, '0),
                     KIND_STATUS, 0, '0));
    add_row(mk_typed(mk(FUNC_UPDATE, '1, 64'h7FFF_FFFF_FFFF_FFFF, 1, '1),
                     KIND_STATUS, 0, '0));
    add_row(mk(FUNC_UPDATE, 64'd5, 64'd0, 0, '0));
    add_row(mk(FUNC_UPDATE, 64'd6, 64'd0, 0, '0));
    add_row(mk(FUNC_UPDATE, 64'd7, 64'd0, 0, '0));
    add_row(mk(FUNC_RANK, 64'd6, '0, 0, '0));
    add_row(mk(FUNC_TOP, '0, '0, 1, 32'h8000_0000));
    add_row(mk(FUNC_UPDATE, 64'd5, -64'sd3, 0, '0));
    add_row(mk(FUNC_TOP, '0, '0, 1, '1));
    add_row(mk_typed(mk(FUNC_TOP, '0, '0, 1, '0), KIND_EMPTY, 0, '0));
    add_row(mk(FUNC_TOP, '0, '0, 1, 32'd2));
    add_row(mk(FUNC_TOP, '0, '0, 0, 32'd1));
    add_row(mk(FUNC_TOP, '0, '0, 1, 32'h7FFF_FFFF));
    add_row(mk(FUNC_RANK, '1, '0, 0, '0));
    add_row(mk(FUNC_RANK, '0, '0, 0, '0));
    add_row(mk(FUNC_RANK, 64'd5, '0, 0, '0));
    add_row(mk(FUNC_IGNORED, '1, '1, 1, '1));
    add_row(mk_typed(mk(FUNC_RANK, 64'd99, '0, 0, '0), KIND_RANK, 0, RANK_ABSENT));

    id_pool.insert(id_pool.size(), '0);
    id_pool.insert(id_pool.size(), '1);
    for (int i = 0; i < 14; i++) id_pool.insert(id_pool.size(), {$urandom, $urandom});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20; rx_idle_pct = 86;
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);

    write_default(7'd0);
    send_item(mk(FUNC_TOP, '0, '0, 0, '0));
    for (int i = 0; i < N_RANDOM / 3; i++) send_item(random_item());

    tx_idle_pct = 86; rx_idle_pct = 20;
    write_default(7'd1);
    send_item(mk(FUNC_TOP, '0, '0, 0, '0));
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_item(mk(FUNC_TOP, '0, '0, 1, -32'sd1));
    for (int i = 0; i < N_RANDOM / 3; i++) send_item(random_item());

    // fill the table to capacity, then push new ids against it
    tx_idle_pct = 0; rx_idle_pct = 0;
    write_default(7'd64);
    for (int i = 0; i < CAP; i++) begin
      k = {$urandom, $urandom};
      id_pool.insert(id_pool.size(), k);
      send_item(mk(FUNC_UPDATE, k, 64'($signed($urandom_range(20)) - 10), 0, '0));
    end
    send_item(mk(FUNC_TOP, '0, '0, 0, '0));
    send_item(mk(FUNC_UPDATE, 64'hDEAD_0000_0000_0001, '1, 0, '0));
    write_default(7'($urandom_range(2, 63)));
    for (int i = 0; i < N_RANDOM / 3; i++) send_item(random_item());

    drain_results();
    $display("%0d items in, %0d results checked: %0d top lists, %0d updates dropped",
             n_items, n_results, n_tops, n_dropped);
    if (errors == 0 && pending_q.size() == 0)
      $display("score_rank_table_tb: PASS");
    else
      $display("score_rank_table_tb: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/srt_pkg.sv
hw/rtl/srt_cell.sv
hw/rtl/score_rank_table.sv
sim/score_rank_table_tb.sv
